// ===== rtl/mcwd_pkg.sv =====
// ----------------------------------------------------------------------------
// mcwd_pkg: shared types and constants for the liveness watchdog
// Operation codes, per-channel record layout and the expiry check.
// ----------------------------------------------------------------------------
package mcwd_pkg;

	localparam int NUM_CHANNELS = 16;

	typedef logic [2:0]  func_t;
	typedef logic [3:0]  chan_t;
	typedef logic [31:0] word_t;

	localparam func_t FN_INIT      = 3'd0;
	localparam func_t FN_KICK      = 3'd1;
	localparam func_t FN_SET_TMO   = 3'd2;
	localparam func_t FN_REGISTER  = 3'd3;
	localparam func_t FN_QUERY     = 3'd4;
	localparam func_t FN_STEP      = 3'd5;
	localparam func_t FN_RESET_REG = 3'd6;

	localparam word_t SANITY_RESET = 32'h7FFF_FFFF;

	typedef struct packed {
		word_t timeout;
		word_t last_kick;
		logic  kicked;
		logic  failed;
		word_t fail_cnt;
	} chan_rec_t;

	typedef struct packed {
		logic clk_err;
		logic expired;
	} check_t;

	function automatic check_t chan_check(chan_rec_t r, word_t now, word_t limit);
		word_t  age;
		check_t c;
		c   = '0;
		age = now - r.last_kick;
		if (r.timeout != '0) begin
			if (!r.kicked) begin
				c.expired = 1'b1;
			end else if (age > limit) begin
				c.clk_err = 1'b1;
			end else begin
				c.expired = (age > r.timeout);
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/mcwd_req_if.sv =====
// ----------------------------------------------------------------------------
// mcwd_req_if: operation request channel
// Valid/ready channel carrying one operation beat.
// ----------------------------------------------------------------------------
interface mcwd_req_if;
	import mcwd_pkg::*;

	logic  valid;
	logic  ready;
	func_t func;
	chan_t channel;
	word_t now_ms;
	word_t timeout_value;

	modport source (output valid, func, channel, now_ms, timeout_value, input ready);
	modport sink (input valid, func, channel, now_ms, timeout_value, output ready);
endinterface

// ===== rtl/mcwd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mcwd_rsp_if: result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface mcwd_rsp_if;
	import mcwd_pkg::*;

	logic       valid;
	logic       ready;
	logic       accepted;
	logic       expired;
	logic [4:0] failed_total;
	chan_t      first_failed_channel;
	logic       first_failed_valid;
	word_t      clock_error_total;
	logic [4:0] registered_total;
	word_t      channel_fail_total;

	modport source (output valid, accepted, expired, failed_total, first_failed_channel,
		first_failed_valid, clock_error_total, registered_total, channel_fail_total,
		input ready);
	modport sink (input valid, accepted, expired, failed_total, first_failed_channel,
		first_failed_valid, clock_error_total, registered_total, channel_fail_total,
		output ready);
endinterface

// ===== rtl/mcwd_chan_mem.sv =====
// ----------------------------------------------------------------------------
// mcwd_chan_mem: per-channel record memory
// One write, one registered read; entries never written read as zero.
// ----------------------------------------------------------------------------
module mcwd_chan_mem #(
	parameter int DEPTH = mcwd_pkg::NUM_CHANNELS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [AW-1:0]       rd_addr,
	output mcwd_pkg::chan_rec_t rd_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  mcwd_pkg::chan_rec_t wr_data
);
	import mcwd_pkg::*;

	chan_rec_t        mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	chan_rec_t        rd_raw_s1;
	logic             rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_raw_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_s1 ? rd_raw_s1 : '0;
endmodule

// ===== rtl/mcwd_order_mem.sv =====
// ----------------------------------------------------------------------------
// mcwd_order_mem: registration order table
// Slot i holds the i-th registered channel; registered read port.
// ----------------------------------------------------------------------------
module mcwd_order_mem #(
	parameter int DEPTH = mcwd_pkg::NUM_CHANNELS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic [AW-1:0]   rd_addr,
	output mcwd_pkg::chan_t rd_data,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  mcwd_pkg::chan_t wr_data
);
	import mcwd_pkg::*;

	chan_t mem_q [DEPTH];
	chan_t rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_s1 <= mem_q[rd_addr];
	end

	assign rd_data = rd_s1;
endmodule

// ===== rtl/multi_channel_liveness_watchdog_unit.sv =====
// ----------------------------------------------------------------------------
// multi_channel_liveness_watchdog_unit: multi-channel liveness watchdog
// Per-channel timeouts, kicks and failure tracking held in a record memory.
//
//   port    | role   | beat
//   --------+--------+-----------------------------------------------
//   req     | sink   | func, channel, now_ms, timeout_value
//   rsp     | source | accepted, expired, totals, channel_fail_total
//   cfg_wr  | write  | age_sanity_limit
//
// Non-step operations: record read, modify and write back, then the result is
// registered. Step: the order-table read, record read and write-back are
// pipelined one channel per cycle over the registered channels. One operation
// is in flight at a time. No clearing pass after reset. A stalled result blocks
// the next operation only once that one has its own result ready.
// ----------------------------------------------------------------------------
module multi_channel_liveness_watchdog_unit #(
	parameter int CHANNELS = mcwd_pkg::NUM_CHANNELS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  mcwd_pkg::word_t   cfg_wr_data,
	mcwd_req_if.sink          req,
	mcwd_rsp_if.source        rsp
);
	import mcwd_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CW = $clog2(CHANNELS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RMW  = 2'd1;
	localparam logic [1:0] S_STEP = 2'd2;
	localparam logic [1:0] S_RES  = 2'd3;

	logic [1:0]          state_q;
	word_t               limit_q;
	logic [CHANNELS-1:0] reg_marks_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       failed_cnt_q;
	chan_t               first_q;
	logic                first_flag_q;
	word_t               clk_err_q;

	func_t               op_func_q;
	chan_t               op_chan_q;
	word_t               op_now_q;
	word_t               op_tmo_q;
	logic                op_valid_q;

	logic                res_accepted_q;
	logic                res_expired_q;
	word_t               res_fail_q;

	logic [CW-1:0]       iss_idx_q;
	logic                vld_s1;
	logic                vld_s2;
	chan_t               ch_s2;

	logic                out_valid_q;
	logic                out_accepted_q;
	logic                out_expired_q;
	logic [4:0]          out_failed_q;
	chan_t               out_first_q;
	logic                out_first_vld_q;
	word_t               out_clk_err_q;
	logic [4:0]          out_reg_total_q;
	word_t               out_fail_q;

	logic [AW-1:0]       op_addr;
	logic                req_chan_ok;
	logic                in_acc;
	logic                step_done;
	logic                reg_ok;

	logic [AW-1:0]       chan_rd_addr;
	chan_rec_t           chan_rd_data;
	logic                chan_wr_en;
	logic [AW-1:0]       chan_wr_addr;
	chan_rec_t           chan_wr_data;
	check_t              ck;

	logic [AW-1:0]       ord_rd_addr;
	chan_t               ord_rd_data;
	logic                ord_wr_en;

	assign op_addr     = AW'(op_chan_q);
	assign req_chan_ok = (int'(req.channel) < CHANNELS);
	assign req.ready   = (state_q == S_IDLE);
	assign in_acc      = req.valid && req.ready;
	assign step_done   = (iss_idx_q >= cnt_q) && !vld_s1 && !vld_s2;
	assign reg_ok      = (cnt_q < CW'(CHANNELS)) && !reg_marks_q[op_addr];
	assign ck          = chan_check(chan_rd_data, op_now_q, limit_q);
	assign ord_rd_addr = iss_idx_q[AW-1:0];
	assign ord_wr_en   = (state_q == S_RMW) && (op_func_q == FN_REGISTER) && op_valid_q
		&& reg_ok;

	always_comb begin
		chan_rd_addr = AW'(req.channel);
		if (state_q == S_STEP) begin
			chan_rd_addr = vld_s1 ? AW'(ord_rd_data) : op_addr;
		end
	end

	always_comb begin
		chan_wr_en   = 1'b0;
		chan_wr_addr = op_addr;
		chan_wr_data = chan_rd_data;
		if (state_q == S_RMW && op_valid_q) begin
			case (op_func_q)
				FN_INIT: begin
					chan_wr_en           = 1'b1;
					chan_wr_data         = '0;
					chan_wr_data.timeout = op_tmo_q;
				end
				FN_KICK: begin
					chan_wr_en             = 1'b1;
					chan_wr_data.last_kick = op_now_q;
					chan_wr_data.kicked    = 1'b1;
				end
				FN_SET_TMO: begin
					chan_wr_en           = 1'b1;
					chan_wr_data.timeout = op_tmo_q;
				end
				default: begin
					chan_wr_en = 1'b0;
				end
			endcase
		end else if (state_q == S_STEP && vld_s2) begin
			chan_wr_en          = 1'b1;
			chan_wr_addr        = AW'(ch_s2);
			chan_wr_data.failed = ck.expired;
			if (ck.expired && !chan_rd_data.failed) begin
				chan_wr_data.fail_cnt = chan_rd_data.fail_cnt + 32'd1;
			end
		end
	end

	mcwd_chan_mem #(
		.DEPTH (CHANNELS),
		.AW    (AW)
	) u_chan_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (chan_rd_addr),
		.rd_data (chan_rd_data),
		.wr_en   (chan_wr_en),
		.wr_addr (chan_wr_addr),
		.wr_data (chan_wr_data)
	);

	mcwd_order_mem #(
		.DEPTH (CHANNELS),
		.AW    (AW)
	) u_order_mem (
		.clk     (clk),
		.rd_addr (ord_rd_addr),
		.rd_data (ord_rd_data),
		.wr_en   (ord_wr_en),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (op_chan_q)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_func_q  <= req.func;
			op_chan_q  <= req.channel;
			op_now_q   <= req.now_ms;
			op_tmo_q   <= req.timeout_value;
			op_valid_q <= req_chan_ok;
		end
		if (state_q == S_STEP && vld_s1) begin
			ch_s2 <= ord_rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			limit_q         <= SANITY_RESET;
			reg_marks_q     <= '0;
			cnt_q           <= '0;
			failed_cnt_q    <= '0;
			first_q         <= '0;
			first_flag_q    <= 1'b0;
			clk_err_q       <= '0;
			res_accepted_q  <= 1'b1;
			res_expired_q   <= 1'b0;
			res_fail_q      <= '0;
			iss_idx_q       <= '0;
			vld_s1          <= 1'b0;
			vld_s2          <= 1'b0;
			out_valid_q     <= 1'b0;
			out_accepted_q  <= 1'b0;
			out_expired_q   <= 1'b0;
			out_failed_q    <= '0;
			out_first_q     <= '0;
			out_first_vld_q <= 1'b0;
			out_clk_err_q   <= '0;
			out_reg_total_q <= '0;
			out_fail_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (out_valid_q && rsp.ready && state_q != S_RES) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						res_accepted_q <= !(req.func == FN_REGISTER && !req_chan_ok);
						res_expired_q  <= 1'b0;
						res_fail_q     <= '0;
						if (req.func == FN_STEP) begin
							failed_cnt_q <= '0;
							first_q      <= '0;
							first_flag_q <= 1'b0;
							iss_idx_q    <= '0;
							vld_s1       <= 1'b0;
							vld_s2       <= 1'b0;
							state_q      <= S_STEP;
						end else begin
							state_q <= req_chan_ok ? S_RMW : S_RES;
							if (req.func == FN_RESET_REG) begin
								reg_marks_q  <= '0;
								cnt_q        <= '0;
								failed_cnt_q <= '0;
								first_q      <= '0;
								first_flag_q <= 1'b0;
								clk_err_q    <= '0;
							end
						end
					end
				end
				S_RMW: begin
					if (op_func_q == FN_REGISTER) begin
						if (reg_ok) begin
							reg_marks_q[op_addr] <= 1'b1;
							cnt_q                <= cnt_q + 1'b1;
						end else begin
							res_accepted_q <= 1'b0;
						end
					end else if (op_func_q == FN_QUERY) begin
						res_expired_q <= ck.expired;
						if (ck.clk_err) begin
							clk_err_q <= clk_err_q + 32'd1;
						end
					end
					res_fail_q <= chan_wr_data.fail_cnt;
					state_q    <= S_RES;
				end
				S_STEP: begin
					if (iss_idx_q < cnt_q) begin
						vld_s1    <= 1'b1;
						iss_idx_q <= iss_idx_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					vld_s2 <= vld_s1;
					if (vld_s2) begin
						if (ck.clk_err) begin
							clk_err_q <= clk_err_q + 32'd1;
						end
						if (ck.expired) begin
							failed_cnt_q <= failed_cnt_q + 1'b1;
							if (!first_flag_q) begin
								first_flag_q <= 1'b1;
								first_q      <= ch_s2;
							end
						end
					end
					if (step_done) begin
						state_q <= op_valid_q ? S_RMW : S_RES;
					end
				end
				S_RES: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q     <= 1'b1;
						out_accepted_q  <= res_accepted_q;
						out_expired_q   <= res_expired_q;
						out_failed_q    <= 5'(failed_cnt_q);
						out_first_q     <= first_flag_q ? first_q : '0;
						out_first_vld_q <= first_flag_q;
						out_clk_err_q   <= clk_err_q;
						out_reg_total_q <= 5'(cnt_q);
						out_fail_q      <= res_fail_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid                = out_valid_q;
	assign rsp.accepted             = out_accepted_q;
	assign rsp.expired              = out_expired_q;
	assign rsp.failed_total         = out_failed_q;
	assign rsp.first_failed_channel = out_first_q;
	assign rsp.first_failed_valid   = out_first_vld_q;
	assign rsp.clock_error_total    = out_clk_err_q;
	assign rsp.registered_total     = out_reg_total_q;
	assign rsp.channel_fail_total   = out_fail_q;

	a_marks_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(reg_marks_q) == int'(cnt_q))
		else $error("registry marks disagree with registry count");

	a_failed_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		failed_cnt_q <= cnt_q)
		else $error("failed total exceeds registered channels");

	a_first_flag_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		first_flag_q == (failed_cnt_q != '0))
		else $error("first-failed flag out of step with failed total");

	a_step_pipe_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP && step_done) |=> !vld_s1 && !vld_s2)
		else $error("step pipeline busy after step completion");
endmodule
